// ===== design/pltc_pkg.sv =====
package pltc_pkg;

  // Item selector carried in tuser.
  typedef enum logic {
    FUNC_MESSAGE = 1'b0,
    FUNC_PASS    = 1'b1
  } func_t;

  // Level codes, both as reported by a message and as qualified.
  typedef enum logic [1:0] {
    LEVEL_FULL    = 2'd0,
    LEVEL_EMPTY   = 2'd1,
    LEVEL_NORMAL  = 2'd2,
    LEVEL_UNKNOWN = 2'd3
  } level_t;

  localparam int LEVEL_CONFIRM = 3;
  localparam int STOP_CONFIRM  = 5;
  localparam int LEVEL_CNT_W   = $clog2(LEVEL_CONFIRM + 1);
  localparam int STOP_CNT_W    = $clog2(STOP_CONFIRM + 1);

  localparam int NET_W  = 14;
  localparam int POT_W  = 10;
  localparam int SEC_W  = 15;
  localparam int MIN_W  = 8;

  localparam logic [NET_W-1:0]        NETWORK_ID_RESET = 14'd2012;
  localparam logic signed [SEC_W-1:0] TIME_RESET       = 15'sd1800;
  localparam logic signed [SEC_W-1:0] TIME_FLOOR       = -15'sd16384;
  localparam logic [MIN_W-1:0]        DURATION_RESET   = 8'd30;

  // Knob mapping constants: minutes = sample * KNOB_SPAN / KNOB_FULL + 1.
  localparam logic [17:0] KNOB_SPAN = 18'd179;
  localparam logic [10:0] KNOB_FULL = 11'd1023;

  // Minutes to seconds as shift and subtract: m * 60 = m * 64 - m * 4.
  function automatic logic signed [SEC_W-1:0] minutes_to_seconds(input logic [MIN_W-1:0] m);
    logic [SEC_W-1:0] wide;
    wide = (SEC_W'(m) << 6) - (SEC_W'(m) << 2);
    return signed'(wide);
  endfunction

endpackage

// ===== design/pump_level_timer_controller.sv =====
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: msg_valid, msg_network, msg_status,
//                                           button_pressed, pot_sample; tuser: func
// m_axis    out  m_axis_tvalid/tready       tdata: motor_on, level_state, seconds_left,
//                                           remaining_minutes, run_minutes
// config    in   cfg_we                     cfg_wdata: network_id
//
// Two register stages: an input register and a result register, with all state
// updated in the single cycle an item moves from the first to the second.
// One item per cycle is sustained unless the output stalls; each result is registered.
// A stalled output holds its result while one more item waits in the input register.
// rst is synchronous and restores the power-on state and network id 2012.
module pump_level_timer_controller (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [13:0]             cfg_wdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [0] msg_valid, [14:1] msg_network, [16:15] msg_status,
  // [17] button_pressed, [27:18] pot_sample, [31:28] zero
  input  logic [31:0]             s_axis_tdata,
  // [0] func
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] motor_on, [2:1] level_state, [17:3] seconds_left,
  // [25:18] remaining_minutes, [33:26] run_minutes, [39:34] zero
  output logic [39:0]             m_axis_tdata
);
  import pltc_pkg::*;

  // Configuration and state.
  logic [NET_W-1:0]         network_id;
  logic                     motor_running;
  level_t                   qualified_level;
  logic signed [SEC_W-1:0]  time_left;
  logic [MIN_W-1:0]         duration_minutes;
  logic [LEVEL_CNT_W-1:0]   full_run, empty_run, normal_run;
  logic [STOP_CNT_W-1:0]    stop_run;

  logic                     motor_running_next;
  level_t                   qualified_level_next;
  logic signed [SEC_W-1:0]  time_left_next;
  logic [MIN_W-1:0]         duration_minutes_next;
  logic [LEVEL_CNT_W-1:0]   full_run_next, empty_run_next, normal_run_next;
  logic [STOP_CNT_W-1:0]    stop_run_next;

  // Input register.
  logic                     in_valid;
  func_t                    in_func;
  logic                     in_msg_valid;
  logic [NET_W-1:0]         in_network;
  level_t                   in_status;
  logic                     in_button;
  logic [MIN_W-1:0]         in_knob_minutes;

  // Result register.
  logic                     out_valid;
  logic                     out_motor;
  level_t                   out_level;
  logic signed [SEC_W-1:0]  out_seconds;
  logic [MIN_W-1:0]         out_run_minutes;
  logic [MIN_W-1:0]         out_remaining;

  logic advance;
  logic s_take;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  // Knob mapping ahead of the input register. The quotient estimate by 1024 is
  // at most one short of the quotient by 1023, so one compare corrects it.
  logic [POT_W-1:0] pot;
  logic [17:0]      knob_prod;
  logic [7:0]       knob_q0;
  logic [10:0]      knob_rem;
  logic [MIN_W-1:0] knob_minutes;

  always_comb begin
    pot          = s_axis_tdata[27:18];
    knob_prod    = 18'(pot) * KNOB_SPAN;
    knob_q0      = knob_prod[17:10];
    knob_rem     = {1'b0, knob_prod[9:0]} + 11'(knob_q0);
    knob_minutes = knob_q0 + MIN_W'(knob_rem >= KNOB_FULL) + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_take) begin
      in_func         <= func_t'(s_axis_tuser);
      in_msg_valid    <= s_axis_tdata[0];
      in_network      <= s_axis_tdata[14:1];
      in_status       <= level_t'(s_axis_tdata[16:15]);
      in_button       <= s_axis_tdata[17];
      in_knob_minutes <= knob_minutes;
    end
  end

  // State update for one item.
  logic signed [SEC_W-1:0] reload_seconds;

  always_comb begin
    reload_seconds        = minutes_to_seconds(duration_minutes);
    motor_running_next    = motor_running;
    qualified_level_next  = qualified_level;
    time_left_next        = time_left;
    duration_minutes_next = duration_minutes;
    full_run_next         = full_run;
    empty_run_next        = empty_run;
    normal_run_next       = normal_run;
    stop_run_next         = stop_run;

    case (in_func)
      FUNC_MESSAGE: begin
        if (in_msg_valid && in_network == network_id) begin
          full_run_next   = '0;
          empty_run_next  = '0;
          normal_run_next = '0;
          case (in_status)
            LEVEL_FULL: begin
              full_run_next = full_run + 1'b1;
              if (full_run_next >= LEVEL_CNT_W'(LEVEL_CONFIRM)) begin
                motor_running_next   = 1'b0;
                time_left_next       = reload_seconds;
                full_run_next        = '0;
                qualified_level_next = LEVEL_FULL;
              end
            end
            LEVEL_EMPTY: begin
              empty_run_next = empty_run + 1'b1;
              if (empty_run_next >= LEVEL_CNT_W'(LEVEL_CONFIRM)) begin
                motor_running_next   = 1'b1;
                empty_run_next       = '0;
                qualified_level_next = LEVEL_EMPTY;
              end
            end
            LEVEL_NORMAL: begin
              normal_run_next = normal_run + 1'b1;
              if (normal_run_next >= LEVEL_CNT_W'(LEVEL_CONFIRM)) begin
                normal_run_next      = '0;
                qualified_level_next = LEVEL_NORMAL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FUNC_PASS: begin
        if (in_button) begin
          motor_running_next = !motor_running;
          if (!motor_running) begin
            time_left_next = reload_seconds;
          end
        end
        if (motor_running_next) begin
          if (time_left_next > TIME_FLOOR) begin
            time_left_next = time_left_next - 15'sd1;
          end
          if (time_left_next <= 15'sd0 || qualified_level == LEVEL_FULL) begin
            stop_run_next = stop_run + 1'b1;
            if (stop_run_next >= STOP_CNT_W'(STOP_CONFIRM)) begin
              motor_running_next = 1'b0;
              time_left_next     = reload_seconds;
              stop_run_next      = '0;
            end
          end else begin
            stop_run_next = '0;
          end
        end else if (in_knob_minutes != duration_minutes) begin
          duration_minutes_next = in_knob_minutes;
          time_left_next        = minutes_to_seconds(in_knob_minutes);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      network_id       <= NETWORK_ID_RESET;
      motor_running    <= 1'b0;
      qualified_level  <= LEVEL_NORMAL;
      time_left        <= TIME_RESET;
      duration_minutes <= DURATION_RESET;
      full_run         <= '0;
      empty_run        <= '0;
      normal_run       <= '0;
      stop_run         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        network_id <= cfg_wdata;
      end
      if (advance) begin
        motor_running    <= motor_running_next;
        qualified_level  <= qualified_level_next;
        time_left        <= time_left_next;
        duration_minutes <= duration_minutes_next;
        full_run         <= full_run_next;
        empty_run        <= empty_run_next;
        normal_run       <= normal_run_next;
        stop_run         <= stop_run_next;
        out_valid        <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_motor       <= motor_running_next;
      out_level       <= qualified_level_next;
      out_seconds     <= time_left_next;
      out_run_minutes <= duration_minutes_next;
    end
  end

  // Minutes left, truncated toward zero, plus one. |t| / 60 = (|t| / 4) / 15, and the
  // quotient by 15 is ((b + 1) * 4369) >> 16, exact for b below 65535.
  logic [SEC_W-1:0] sec_abs;
  logic [12:0]      sec_quarter;
  logic [25:0]      div_prod;
  logic [8:0]       min_mag;
  logic [8:0]       min_signed;

  always_comb begin
    sec_abs       = out_seconds[SEC_W-1] ? SEC_W'(-out_seconds) : SEC_W'(out_seconds);
    sec_quarter   = sec_abs[SEC_W-1:2];
    div_prod      = (26'(sec_quarter) + 26'd1) * 26'd4369;
    min_mag       = div_prod[24:16];
    min_signed    = out_seconds[SEC_W-1] ? (~min_mag + 9'd1) : min_mag;
    out_remaining = min_signed[MIN_W-1:0] + 8'd1;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_run_minutes, out_remaining, out_seconds,
                          out_level, out_motor};

endmodule

// ===== bench/pump_level_timer_controller_tb.sv =====
module pump_level_timer_controller_tb;
  import pltc_pkg::*;

  typedef struct packed {
    func_t            func;
    logic             valid;
    logic [NET_W-1:0] net;
    level_t           status;
    logic             button;
    logic [POT_W-1:0] pot;
  } tank_item_t;

  typedef struct packed {
    logic                    motor;
    level_t                  level;
    logic signed [SEC_W-1:0] secs;
    logic [MIN_W-1:0]        rem;
    logic [MIN_W-1:0]        run;
  } tank_status_t;

  typedef struct packed {
    tank_item_t   item;
    logic         typed;
    tank_status_t status;
  } directed_row_t;

  localparam int SEC_FLOOR = -16384;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [13:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [0] msg_valid, [14:1] msg_network, [16:15] msg_status,
  // [17] button_pressed, [27:18] pot_sample, [31:28] zero
  logic [31:0] s_axis_tdata;
  // [0] func
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] motor_on, [2:1] level_state, [17:3] seconds_left,
  // [25:18] remaining_minutes, [33:26] run_minutes, [39:34] zero
  logic [39:0] m_axis_tdata;

  pump_level_timer_controller DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the controller state.
  logic [NET_W-1:0] net_st     = NETWORK_ID_RESET;
  logic             motor_st   = 1'b0;
  level_t           level_st   = LEVEL_NORMAL;
  int               secs_st    = 1800;
  int               mins_st    = 30;
  int               full_cnt   = 0;
  int               empty_cnt  = 0;
  int               normal_cnt = 0;
  int               stop_cnt   = 0;

  tank_status_t  status_q[$];
  tank_item_t    plan_q[$];
  directed_row_t directed_q[$];

  int src_idle_pct  = 19;
  int sink_idle_pct = 61;
  int fail_count    = 0;

  function automatic tank_status_t step_tank(input tank_item_t it);
    tank_status_t r;
    int           knob_mins;
    if (it.func == FUNC_MESSAGE) begin
      if (it.valid && it.net == net_st) begin
        if (it.status == LEVEL_FULL) begin
          full_cnt++;
          if (full_cnt >= LEVEL_CONFIRM) begin
            motor_st = 1'b0;
            secs_st  = mins_st * 60;
            full_cnt = 0;
            level_st = LEVEL_FULL;
          end
        end else begin
          full_cnt = 0;
        end
        if (it.status == LEVEL_EMPTY) begin
          empty_cnt++;
          if (empty_cnt >= LEVEL_CONFIRM) begin
            motor_st  = 1'b1;
            empty_cnt = 0;
            level_st  = LEVEL_EMPTY;
          end
        end else begin
          empty_cnt = 0;
        end
        if (it.status == LEVEL_NORMAL) begin
          normal_cnt++;
          if (normal_cnt >= LEVEL_CONFIRM) begin
            level_st   = LEVEL_NORMAL;
            normal_cnt = 0;
          end
        end else begin
          normal_cnt = 0;
        end
      end
    end else begin
      if (it.button) begin
        if (!motor_st) begin
          motor_st = 1'b1;
          secs_st  = mins_st * 60;
        end else begin
          motor_st = 1'b0;
        end
      end
      if (motor_st) begin
        if (secs_st > SEC_FLOOR) secs_st--;
        if (secs_st <= 0 || level_st == LEVEL_FULL) begin
          stop_cnt++;
          if (stop_cnt >= STOP_CONFIRM) begin
            motor_st = 1'b0;
            secs_st  = mins_st * 60;
            stop_cnt = 0;
          end
        end else begin
          stop_cnt = 0;
        end
      end else begin
        knob_mins = int'(it.pot) * 179 / 1023 + 1;
        if (knob_mins != mins_st) begin
          mins_st = knob_mins;
          secs_st = mins_st * 60;
        end
      end
    end
    r.motor = motor_st;
    r.level = level_st;
    r.secs  = SEC_W'(secs_st);
    r.rem   = MIN_W'(secs_st / 60 + 1);
    r.run   = MIN_W'(mins_st);
    return r;
  endfunction

  function automatic tank_item_t any_item();
    tank_item_t it;
    it.func   = func_t'($urandom_range(1));
    it.valid  = 1'($urandom_range(1));
    it.net    = NET_W'($urandom_range(9999));
    it.status = level_t'($urandom_range(3));
    it.button = 1'($urandom_range(1));
    it.pot    = POT_W'($urandom_range(1023));
    return it;
  endfunction

  // Queues up one short scenario, chosen with the current pump state in mind.
  function automatic void plan_burst();
    tank_item_t it;
    int         kind;
    int         n;
    int         code;
    kind = $urandom_range(99);
    if (kind < 45) begin
      code = $urandom_range(3);
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : LEVEL_CONFIRM;
      repeat (n) begin
        it        = any_item();
        it.func   = FUNC_MESSAGE;
        it.valid  = 1'b1;
        it.net    = net_st;
        it.status = level_t'(code);
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) it.valid = 1'b0;
          else it.net = (net_st == 9999) ? '0 : net_st + 1'b1;
        end
        plan_q.push_back(it);
      end
    end else if (kind < 80) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        it        = any_item();
        it.func   = FUNC_PASS;
        it.button = ($urandom_range(6) == 0);
        plan_q.push_back(it);
      end
    end else if (kind < 90) begin
      // Set a one minute run, start it and let the timer expire.
      it        = any_item();
      it.func   = FUNC_PASS;
      it.button = motor_st;
      it.pot    = POT_W'($urandom_range(5));
      plan_q.push_back(it);
      it        = any_item();
      it.func   = FUNC_PASS;
      it.button = 1'b1;
      plan_q.push_back(it);
      repeat (66) begin
        it        = any_item();
        it.func   = FUNC_PASS;
        it.button = 1'b0;
        plan_q.push_back(it);
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) plan_q.push_back(any_item());
    end
  endfunction

  function automatic void add_row(input func_t f, input logic v, input int net,
                                  input level_t st, input logic b, input int pot,
                                  input logic typed, input logic m, input level_t lv,
                                  input int secs, input int rem, input int run);
    directed_row_t row;
    row.item         = '{f, v, NET_W'(net), st, b, POT_W'(pot)};
    row.typed        = typed;
    row.status.motor = m;
    row.status.level = lv;
    row.status.secs  = SEC_W'(secs);
    row.status.rem   = MIN_W'(rem);
    row.status.run   = MIN_W'(run);
    directed_q.push_back(row);
  endfunction

  task automatic send_item(input tank_item_t it, input logic typed,
                           input tank_status_t typed_status);
    tank_status_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {4'b0, it.pot, it.button, it.status, it.net, it.valid};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predicted = step_tank(it);
    status_q.push_back(typed ? typed_status : predicted);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_network(input logic [NET_W-1:0] id);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_we    <= 1'b0;
    net_st = id;
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    tank_status_t want;
    tank_status_t got;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.motor = m_axis_tdata[0];
      got.level = level_t'(m_axis_tdata[2:1]);
      got.secs  = m_axis_tdata[17:3];
      got.rem   = m_axis_tdata[25:18];
      got.run   = m_axis_tdata[33:26];
      if (status_q.size() == 0) begin
        $error("result item with no expectation waiting: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = status_q.pop_front();
        if (got.motor !== want.motor) begin
          $error("motor_on: expected %0d, actual %0d", want.motor, got.motor);
          fail_count++;
        end
        if (got.level !== want.level) begin
          $error("level_state: expected %0d, actual %0d", want.level, got.level);
          fail_count++;
        end
        if (got.secs !== want.secs) begin
          $error("seconds_left: expected %0d, actual %0d", want.secs, got.secs);
          fail_count++;
        end
        if (got.rem !== want.rem) begin
          $error("remaining_minutes: expected %0d, actual %0d", want.rem, got.rem);
          fail_count++;
        end
        if (got.run !== want.run) begin
          $error("run_minutes: expected %0d, actual %0d", want.run, got.run);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("** pump_level_timer_controller: FAILED **");
    $finish;
  end

  initial begin
    int sent;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_MESSAGE;

    // Knob extremes, then messages that must be ignored.
    add_row(FUNC_PASS, 1, 9999, LEVEL_UNKNOWN, 0, 0, 1, 0, LEVEL_NORMAL, 60, 2, 1);
    add_row(FUNC_PASS, 0, 2012, LEVEL_FULL, 0, 1023, 1, 0, LEVEL_NORMAL, 10800, 181, 180);
    add_row(FUNC_MESSAGE, 0, 2012, LEVEL_FULL, 1, 1023, 1, 0, LEVEL_NORMAL, 10800, 181, 180);
    add_row(FUNC_MESSAGE, 1, 9999, LEVEL_FULL, 1, 0, 1, 0, LEVEL_NORMAL, 10800, 181, 180);
    // Three full codes qualify full.
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_FULL, 1, 0, 1, 0, LEVEL_NORMAL, 10800, 181, 180);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_FULL, 0, 1023, 1, 0, LEVEL_NORMAL, 10800, 181, 180);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_FULL, 1, 512, 1, 0, LEVEL_FULL, 10800, 181, 180);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_UNKNOWN, 0, 0, 1, 0, LEVEL_FULL, 10800, 181, 180);
    // An unrecognised code breaks the empty run; three more start the pump.
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_EMPTY, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_UNKNOWN, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_EMPTY, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_EMPTY, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_EMPTY, 0, 0, 1, 1, LEVEL_EMPTY, 10800, 181, 180);
    // Running pass, button stop with knob read, button start with reload.
    add_row(FUNC_PASS, 1, 2012, LEVEL_FULL, 0, 300, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_PASS, 0, 0, LEVEL_EMPTY, 1, 512, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_PASS, 1, 2012, LEVEL_NORMAL, 1, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    // Full level stops the pump; a manual start then stops after five passes.
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_FULL, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_FULL, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_MESSAGE, 1, 2012, LEVEL_FULL, 0, 0, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    add_row(FUNC_PASS, 1, 16383, LEVEL_UNKNOWN, 1, 1000, 0, 0, LEVEL_NORMAL, 0, 0, 0);
    repeat (4) add_row(FUNC_PASS, 1, 2012, LEVEL_EMPTY, 0, 77, 0, 0, LEVEL_NORMAL, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_item(directed_q[i].item, directed_q[i].typed,
                                      directed_q[i].status);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 19;
          sink_idle_pct = 61;
          write_network('0);
        end
        1: begin
          src_idle_pct  = 61;
          sink_idle_pct = 19;
          write_network(NET_W'(9999));
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          write_network(NET_W'($urandom_range(9999)));
        end
      endcase
      plan_q.delete();
      sent = 0;
      while (sent < 220) begin
        if (plan_q.size() == 0) plan_burst();
        send_item(plan_q.pop_front(), 1'b0, '0);
        sent++;
        if (phase == 1 && sent == 110) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** pump_level_timer_controller: PASSED **");
    end else begin
      $display("** pump_level_timer_controller: FAILED **");
    end
    $finish;
  end

endmodule
